[rtl/mount_mapping_table_macros.svh]
// Assertion macros used by the checker file mmt_checker.sv.
`ifndef MOUNT_MAPPING_TABLE_MACROS_SVH
`define MOUNT_MAPPING_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mount table check failed");

// Next-cycle implication, disabled while reset is asserted
`define MMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mount table check failed");

`endif

[rtl/mmt_pkg.sv]
`default_nettype none

package mmt_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 64;

    // Action codes
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] inode_number;
        logic [1:0]  source_partition;
        logic [1:0]  target_partition;
    } req_t;

    // Response word
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] mapped_partition;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic [31:0] inode;
        logic [1:0]  part;
        logic [1:0]  target;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic cmp;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic match;
        logic last;
        logic rsp_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/mmt_ctrl.sv]
`default_nettype none

module mmt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mmt_pkg::stat_t stat,
    output mmt_pkg::cmd_t      cmd
);
    import mmt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_CMP    = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
                if (req_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (stat.match || stat.last)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_COMMIT:
            begin
                // hold until the response register is free
                if (stat.rsp_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mmt_dp.sv]
`default_nettype none

module mmt_dp #(
    parameter int TABLE_ENTRIES = mmt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mmt_pkg::req_t req,
    input  wire mmt_pkg::cmd_t cmd,
    output mmt_pkg::stat_t     stat,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mmt_pkg::rsp_t      rsp
);
    import mmt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Table storage and valid bits
    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    req_t             req_reg;
    entry_t           rd_entry_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             free_found_reg;
    logic             hit_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;

    logic             match;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             set_valid;
    logic             clr_valid;
    rsp_t             rsp_next;
    logic             rsp_valid_next;
    entry_t           wr_entry;

    // Key compare on the entry read last
    assign match = rd_valid_reg
                 && (rd_entry_reg.inode == req_reg.inode_number)
                 && (rd_entry_reg.part == req_reg.source_partition);

    assign stat.match    = match;
    assign stat.last     = (idx_reg == LAST_IDX);
    assign stat.rsp_free = !rsp_valid_reg || rsp_ready;

    assign wr_entry = '{inode:  req_reg.inode_number,
                        part:   req_reg.source_partition,
                        target: req_reg.target_partition};

    // Outcome of the finished scan
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = hit_reg ? idx_reg : free_idx_reg;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        rsp_next  = '{status: ST_OK, mapped_partition: 2'd0};
        unique case (req_reg.action)
            ACT_LOOKUP:
            begin
                if (hit_reg)
                begin
                    rsp_next.mapped_partition = rd_entry_reg.target;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            ACT_INSERT:
            begin
                if (hit_reg)
                begin
                    wr_en = cmd.commit;
                end
                else if (free_found_reg)
                begin
                    wr_en     = cmd.commit;
                    set_valid = cmd.commit;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            ACT_REMOVE:
            begin
                if (hit_reg)
                begin
                    clr_valid = cmd.commit;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                // unused code: no change, plain success
            end
        endcase
    end

    assign rsp_valid_next = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.rd)
        begin
            rd_entry_reg <= mem[idx_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
        if (cmd.cmp && !rd_valid_reg && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
    end

    // Scan control and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.load)
            begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
                hit_reg        <= 1'b0;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[idx_reg];
            end
            if (cmd.cmp)
            begin
                if (!rd_valid_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                else if (idx_reg != LAST_IDX)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/mount_mapping_table.sv]
// Each request scans the table from entry 0 and stops at the first match;
// a miss, a fresh insert or a full table scans all TABLE_ENTRIES entries.
// Throughput: one request per scan; the scan reads one entry per READ/CMP
// state pair, and COMMIT waits until the response register is free.
// Reset (rst_n, async, active low) clears all valid bits at once: the table
// is empty and ready as soon as reset is released.
`default_nettype none

module mount_mapping_table #(
    parameter int TABLE_ENTRIES = mmt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mmt_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output mmt_pkg::rsp_t      rsp
);
    import mmt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    mmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, compare and response register
    mmt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[rtl/mmt_checker.sv]
`default_nettype none

`include "mount_mapping_table_macros.svh"

module mmt_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire mmt_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire mmt_pkg::rsp_t rsp
);
    import mmt_pkg::*;

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    // Waiting request word holds until taken
    `MMT_ASSERT_NEXT(a_req_hold, clk, rst_n, req_valid && !req_ready, req_valid && $stable(req))

    // Stalled response word holds
    `MMT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // One request in flight: busy right after acceptance
    `MMT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_fire, !req_ready)

    // Only a successful lookup carries a partition
    `MMT_ASSERT_IMPLY(a_mapped_zero, clk, rst_n, rsp_valid && (rsp.status != ST_OK), rsp.mapped_partition == 2'd0)

    // A response needs at least a read, a compare and a commit
    `MMT_ASSERT_IMPLY(a_min_latency, clk, rst_n, $rose(rsp_valid), !$past(req_fire, 1) && !$past(req_fire, 2))

endmodule

bind mount_mapping_table mmt_checker u_mmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
